@@ rtl/ltx_pkg.sv @@
// Shared types, widths and constant tables for the lat-long texel address block.
// Used by ltx_isqrt, ltx_cordic and latlong_texel_address. No dependencies.
package ltx_pkg;

  // Field and register widths
  localparam int COMP_W   = 16;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 12;
  localparam int FRAC_W   = 16;
  localparam int COL_W    = 12;
  localparam int ROW_W    = 11;
  localparam int IDX_W    = 23;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 2048;

  // Components are scaled up by this many bits before the angle work
  localparam int SCALE_SH = 30 - COMP_W;

  // Register indexes
  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_t;

  // CORDIC datapath
  localparam int CW            = 33;  // vector component width
  localparam int AW            = 35;  // angle accumulator, 2^-32 turn units
  localparam int CORDIC_STEPS  = 24;
  localparam int CORDIC_STAGES = CORDIC_STEPS / 2;

  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41721,     30'd20860,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  localparam logic signed [AW-1:0] HALF_TURN = AW'(32'h8000_0000);

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [AW-1:0] acc;
  } cstage_t;

  // Integer square root datapath
  localparam int SQ_IN_W   = 60;
  localparam int SQ_RT_W   = 61;
  localparam int SQ_STEPS  = 30;
  localparam int SQ_STAGES = SQ_STEPS / 2;
  localparam int SQ_TOP    = 58;   // exponent of the first trial bit
  localparam int ROOT_W    = 30;

  typedef struct packed {
    logic [SQ_IN_W-1:0] rem;
    logic [SQ_RT_W-1:0] root;
  } sqstage_t;

  // Overall pipeline: stage of the output register
  localparam int OUT_STAGE = 33;

  // One CORDIC vectoring step, fixed i per instance so the shifts are wiring
  function automatic cstage_t cordic_iter(input cstage_t s, input int unsigned i);
    cstage_t o;
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;
    logic signed [AW-1:0] ang;
    da  = s.b >>> i;
    db  = s.a >>> i;
    ang = AW'(ATAN_TURNS[i]);
    if (!s.a[CW-1]) begin
      o.b   = s.b + db;
      o.a   = s.a - da;
      o.acc = s.acc + ang;
    end else begin
      o.b   = s.b - db;
      o.a   = s.a + da;
      o.acc = s.acc - ang;
    end
    return o;
  endfunction

  // One restoring square root step
  function automatic sqstage_t sqrt_iter(input sqstage_t s, input int unsigned j);
    sqstage_t o;
    logic [SQ_RT_W-1:0] bitv;
    logic [SQ_RT_W-1:0] trial;
    bitv  = SQ_RT_W'(1) << (SQ_TOP - 2 * j);
    trial = s.root + bitv;
    if ({1'b0, s.rem} >= trial) begin
      o.rem  = s.rem - trial[SQ_IN_W-1:0];
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage

@@ rtl/ltx_isqrt.sv @@
// Pipelined integer square root, two restoring steps per stage.
// Depends on ltx_pkg.
module ltx_isqrt import ltx_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  n_in,
  output logic [ROOT_W-1:0]   root_out
);

  sqstage_t st_r [SQ_STAGES];
  sqstage_t init_s;

  assign init_s.rem  = n_in;
  assign init_s.root = '0;

  // Stage k does steps 2k and 2k+1
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    sqstage_t prev_s;
    if (k == 0) begin : g_first
      assign prev_s = init_s;
    end else begin : g_next
      assign prev_s = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= sqrt_iter(sqrt_iter(prev_s, 2 * k), 2 * k + 1);
      end
    end
  end

  assign root_out = st_r[SQ_STAGES-1].root[ROOT_W-1:0];

endmodule

@@ rtl/ltx_cordic.sv @@
// Pipelined CORDIC vectoring: atan2(a, b) in 2^-32 turn units.
// Half-turn pre-rotation stage, then two steps per stage. Depends on ltx_pkg.
module ltx_cordic import ltx_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] a_in,
  input  logic signed [CW-1:0] b_in,
  output logic signed [AW-1:0] acc_out
);

  cstage_t st_r [CORDIC_STAGES+1];
  cstage_t pre_nxt;

  // Turn a vector with negative b by a half turn
  always_comb begin
    if (b_in[CW-1]) begin
      pre_nxt.acc = a_in[CW-1] ? -HALF_TURN : HALF_TURN;
      pre_nxt.a   = -a_in;
      pre_nxt.b   = -b_in;
    end else begin
      pre_nxt.acc = '0;
      pre_nxt.a   = a_in;
      pre_nxt.b   = b_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= pre_nxt;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= cordic_iter(cordic_iter(st_r[k], 2 * k), 2 * k + 1);
      end
    end
  end

  assign acc_out = st_r[CORDIC_STAGES].acc;

endmodule

@@ rtl/latlong_texel_address.sv @@
// Top level: direction to lat-long texel address, fully pipelined.
// Depends on ltx_pkg, ltx_isqrt and ltx_cordic.
//
//  channel | ports              | payload
//  input   | in_tvalid/tready   | in_tdata  = dir_x, dir_y, dir_z
//  result  | out_tvalid/tready  | out_tdata = u_frac, v_frac, texel_col, texel_row,
//          |                    |             texel_index; out_tuser = map_empty
//  config  | cfg_wr_en          | cfg_addr (0 width, 1 height), cfg_wdata
//
// One item per cycle while the result is not stalled; the result register is stage 33
// (34 register stages; the 15-stage square root followed by the 13-stage polar CORDIC
// set the depth).
// Reset clears the valid bits and the map size registers.
// A stalled result freezes the whole pipeline; in_tready = !out_tvalid | out_tready.
module latlong_texel_address import ltx_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,   // dir_x, dir_y, dir_z
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [79:0]         out_tdata,  // u_frac, v_frac, texel_col, texel_row, texel_index, pad
  output logic                out_tuser,  // map_empty
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_addr,
  input  logic [WIDTH_W-1:0]  cfg_wdata
);

  logic en;
  logic vld_r [OUT_STAGE+1];

  // Config registers
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [WIDTH_W-1:0]  w_sat;
  logic [HEIGHT_W-1:0] h_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MAP_WIDTH:  width_r  <= cfg_wdata;
        REG_MAP_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_sat = (width_r > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_r;
  assign h_sat = (height_r > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : height_r;

  // Global advance
  assign en        = !vld_r[OUT_STAGE] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= OUT_STAGE; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int s = 1; s <= OUT_STAGE; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // Stage 0: input capture
  logic signed [COMP_W-1:0] x0_r, y0_r, z0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_tdata[15:0];
      y0_r <= in_tdata[31:16];
      z0_r <= in_tdata[47:32];
    end
  end

  // Scaled components
  logic signed [CW-1:0] xs0, zs0;
  assign xs0 = {{(CW-COMP_W-SCALE_SH){x0_r[COMP_W-1]}}, x0_r, {SCALE_SH{1'b0}}};
  assign zs0 = {{(CW-COMP_W-SCALE_SH){z0_r[COMP_W-1]}}, z0_r, {SCALE_SH{1'b0}}};

  // Special-case flags: {zero xz, y > 0, y < 0}
  logic [2:0] flag0;
  assign flag0 = {(x0_r == '0) && (z0_r == '0),
                  !y0_r[COMP_W-1] && (y0_r != '0),
                  y0_r[COMP_W-1]};

  logic [2:0] flag_d_r [29];
  always_ff @(posedge clk) begin
    if (en) begin
      flag_d_r[0] <= flag0;
      for (int s = 1; s < 29; s++) flag_d_r[s] <= flag_d_r[s-1];
    end
  end

  // y delay to the polar CORDIC input
  logic signed [COMP_W-1:0] y_d_r [16];
  always_ff @(posedge clk) begin
    if (en) begin
      y_d_r[0] <= y0_r;
      for (int s = 1; s < 16; s++) y_d_r[s] <= y_d_r[s-1];
    end
  end

  // Stage 1: squares
  logic signed [31:0] xx1_r, zz1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xx1_r <= x0_r * x0_r;
      zz1_r <= z0_r * z0_r;
    end
  end

  // Radius in the xz plane
  logic [31:0]         sum_sq;
  logic [SQ_IN_W-1:0]  n1;
  logic [ROOT_W-1:0]   r16;
  assign sum_sq = 32'(xx1_r) + 32'(zz1_r);
  assign n1     = {sum_sq, {(2*SCALE_SH){1'b0}}};

  ltx_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .n_in     (n1),
    .root_out (r16)
  );

  // Azimuth atan2(x, z), ready at stage 13
  logic signed [AW-1:0] az13;
  ltx_cordic u_cordic_az (
    .clk     (clk),
    .en      (en),
    .a_in    (xs0),
    .b_in    (zs0),
    .acc_out (az13)
  );

  logic signed [AW-1:0] az_d_r [16];
  always_ff @(posedge clk) begin
    if (en) begin
      az_d_r[0] <= az13;
      for (int s = 1; s < 16; s++) az_d_r[s] <= az_d_r[s-1];
    end
  end

  // Polar atan2(r, y), ready at stage 29
  logic signed [CW-1:0] ra16, ys16;
  logic signed [AW-1:0] po29;
  assign ra16 = {{(CW-ROOT_W){1'b0}}, r16};
  assign ys16 = {{(CW-COMP_W-SCALE_SH){y_d_r[15][COMP_W-1]}}, y_d_r[15], {SCALE_SH{1'b0}}};

  ltx_cordic u_cordic_po (
    .clk     (clk),
    .en      (en),
    .a_in    (ra16),
    .b_in    (ys16),
    .acc_out (po29)
  );

  // Stage 30: fractions with rounding, saturation and special cases
  logic [AW-1:0]     u_sum, v_sum;
  logic [FRAC_W-1:0] u_nxt, v_nxt;
  logic [FRAC_W-1:0] u30_r, v30_r;
  logic [2:0]        f29;

  assign f29   = flag_d_r[28];
  assign u_sum = az_d_r[15] + HALF_TURN + AW'(32'h0000_8000);
  assign v_sum = po29 + AW'(32'h0000_4000);

  always_comb begin
    if (f29[2]) begin
      u_nxt = 16'h8000;
      if (f29[1])      v_nxt = 16'h0000;
      else if (f29[0]) v_nxt = 16'hFFFF;
      else             v_nxt = 16'h8000;
    end else begin
      u_nxt = u_sum[31:16];
      if (po29[AW-1] || (po29 == '0)) v_nxt = '0;
      else if (v_sum[AW-1:31] != '0)  v_nxt = 16'hFFFF;
      else                            v_nxt = v_sum[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u30_r <= u_nxt;
      v30_r <= v_nxt;
    end
  end

  // Stage 31: scale by map size
  logic [FRAC_W+WIDTH_W-1:0]  uw31_r;
  logic [FRAC_W+HEIGHT_W-1:0] vh31_r;
  logic [FRAC_W-1:0]          u31_r, v31_r;
  always_ff @(posedge clk) begin
    if (en) begin
      uw31_r <= u30_r * w_sat;
      vh31_r <= v30_r * h_sat;
      u31_r  <= u30_r;
      v31_r  <= v30_r;
    end
  end

  // Stage 32: column and clamped row
  logic              empty;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [HEIGHT_W-1:0] row_raw;
  logic [HEIGHT_W-1:0] h_m1;
  logic [COL_W-1:0]  col32_r;
  logic [ROW_W-1:0]  row32_r;
  logic              empty32_r;
  logic [FRAC_W-1:0] u32_r, v32_r;

  assign empty   = (w_sat == '0) || (h_sat == '0);
  assign row_raw = vh31_r[FRAC_W+HEIGHT_W-1:FRAC_W];
  assign h_m1    = h_sat - HEIGHT_W'(1);

  always_comb begin
    if (empty) begin
      col_nxt = '0;
      row_nxt = '0;
    end else begin
      col_nxt = uw31_r[FRAC_W+COL_W-1:FRAC_W];
      row_nxt = (row_raw > h_m1) ? h_m1[ROW_W-1:0] : row_raw[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col32_r   <= col_nxt;
      row32_r   <= row_nxt;
      empty32_r <= empty;
      u32_r     <= u31_r;
      v32_r     <= v31_r;
    end
  end

  // Stage 33: linear address and output register
  logic [ROW_W+WIDTH_W-1:0] rw_prod;
  logic [IDX_W-1:0]         idx_nxt;
  logic [IDX_W-1:0]         idx33_r;
  logic [COL_W-1:0]         col33_r;
  logic [ROW_W-1:0]         row33_r;
  logic                     empty33_r;
  logic [FRAC_W-1:0]        u33_r, v33_r;

  assign rw_prod = row32_r * w_sat;
  assign idx_nxt = rw_prod[IDX_W-1:0] + IDX_W'(col32_r);

  always_ff @(posedge clk) begin
    if (en) begin
      idx33_r   <= idx_nxt;
      col33_r   <= col32_r;
      row33_r   <= row32_r;
      empty33_r <= empty32_r;
      u33_r     <= u32_r;
      v33_r     <= v32_r;
    end
  end

  assign out_tvalid = vld_r[OUT_STAGE];
  assign out_tdata  = {2'b00, idx33_r, row33_r, col33_r, v33_r, u33_r};
  assign out_tuser  = empty33_r;

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for latlong_texel_address: direction items in, texel address items out.
// Depends on ltx_pkg and the RTL of latlong_texel_address; expected items come from a
// local bit-exact predictor of the CORDIC / square root arithmetic.
`timescale 1ns / 100ps

module tb_top;
  import ltx_pkg::*;

  localparam longint HALF_T   = 64'sd2147483648;
  localparam int     LIMIT    = 400000;
  localparam int     SETTLE   = 48;
  localparam int     N_PHASES = 9;

  typedef struct packed {
    logic [15:0] u;
    logic [15:0] v;
    logic [11:0] col;
    logic [10:0] row;
    logic [22:0] idx;
    logic        empty;
  } texel_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 typed;
    texel_t             res;
  } dir_row_t;

  typedef struct {
    int w, h, n;
    bit fast;
  } phase_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [79:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_wr_en;
  logic [0:0]        cfg_addr;
  logic [WIDTH_W-1:0] cfg_wdata;

  texel_t texel_q[$];
  int     mismatches;
  int     cycles;
  int     rx_stall;
  bit     rx_fast;
  int     width_reg, height_reg;

  latlong_texel_address DUT (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("latlong_texel_address: mismatch");
      $finish;
    end
  end

  // CORDIC atan2 in 2^-32 turn units, arithmetic shifts on 64-bit signed values
  function automatic longint turns_atan2(longint a, longint b);
    longint acc, da, db;
    acc = 0;
    if (b < 0) begin
      acc = (a >= 0) ? HALF_T : -HALF_T;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (a >= 0) begin
        b += db; a -= da; acc += longint'(ATAN_TURNS[i]);
      end else begin
        b -= db; a += da; acc -= longint'(ATAN_TURNS[i]);
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned rem, root, bitv;
    rem = n; root = 0; bitv = 64'd1 << 62;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Expected address item for one direction under the current map size
  function automatic texel_t texel_of(logic signed [15:0] dx, logic signed [15:0] dy,
                                      logic signed [15:0] dz);
    texel_t r;
    longint x, y, z, rad, az, po, sum;
    longint unsigned u, v, w, h, c, rw;
    x = longint'(dx) <<< SCALE_SH;
    y = longint'(dy) <<< SCALE_SH;
    z = longint'(dz) <<< SCALE_SH;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (x == 0 && z == 0) begin
      u = 16'h8000;
      v = (y > 0) ? 0 : (y < 0) ? 16'hFFFF : 16'h8000;
    end else begin
      rad = longint'(root_floor(x * x + z * z));
      az  = turns_atan2(x, z);
      po  = turns_atan2(rad, y);
      sum = az + HALF_T + 32768;
      u   = (sum >> 16) & 64'hFFFF;
      if (po <= 0) v = 0;
      else begin
        v = longint'(po + 16384) >> 15;
        if (v > 16'hFFFF) v = 16'hFFFF;
      end
    end
    r = '0;
    r.u = u[15:0];
    r.v = v[15:0];
    r.empty = (w == 0 || h == 0);
    if (!r.empty) begin
      c  = ((u * w) >> 16) % w;
      rw = (v * h) >> 16;
      if (rw > h - 1) rw = h - 1;
      r.col = c[11:0];
      r.row = rw[10:0];
      r.idx = 23'(rw * w + c);
    end
    return r;
  endfunction

  // Result side: random back-pressure, drawn per item
  always @(negedge clk) begin
    out_tready <= (rx_stall == 0);
    if (rx_stall > 0) rx_stall <= rx_stall - 1;
  end

  // Result checker
  always @(posedge clk) begin
    texel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{u: out_tdata[15:0], v: out_tdata[31:16], col: out_tdata[43:32],
              row: out_tdata[54:44], idx: out_tdata[77:55], empty: out_tuser};
      rx_stall <= rx_fast ? 0 : $urandom_range(0, 17);
      if (texel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", got);
      end else begin
        want = texel_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("item mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  task automatic send_dir(logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] z, int gap, bit typed, texel_t res);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    texel_q = {texel_q, (typed ? res : texel_of(x, y, z))};
  endtask

  // Lower valid and let the pipeline empty out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (texel_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= WIDTH_W'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_MAP_WIDTH) width_reg = val & 16'h1FFF;
    else height_reg = val & 16'h0FFF;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 8)) - 4);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t dir_tab[$];
  phase_t   phases[N_PHASES];

  initial begin
    int gap;
    texel_t nil;
    nil = '0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    mismatches = 0; cycles = 0; rx_stall = 0; rx_fast = 1'b0;
    width_reg = 0; height_reg = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows for a saturated 4096 x 2048 map
    dir_tab = '{
      '{0, 0, 0, 1, '{16'h8000, 16'h8000, 12'd2048, 11'd1024, 23'd4196352, 1'b0}},
      '{0, 16'sh7FFF, 0, 1, '{16'h8000, 16'h0000, 12'd2048, 11'd0, 23'd2048, 1'b0}},
      '{0, 1, 0, 1, '{16'h8000, 16'h0000, 12'd2048, 11'd0, 23'd2048, 1'b0}},
      '{0, 16'sh8000, 0, 1, '{16'h8000, 16'hFFFF, 12'd2048, 11'd2047, 23'd8386560, 1'b0}},
      '{0, -1, 0, 1, '{16'h8000, 16'hFFFF, 12'd2048, 11'd2047, 23'd8386560, 1'b0}},
      '{16'sh7FFF, 0, 0, 0, nil}, '{16'sh8000, 0, 0, 0, nil},
      '{0, 0, 16'sh7FFF, 0, nil}, '{0, 0, 16'sh8000, 0, nil},
      '{0, 0, -1, 0, nil}, '{1, 0, -1, 0, nil}, '{-1, 0, -1, 0, nil},
      '{16'sh8000, 16'sh8000, 16'sh8000, 0, nil},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, nil},
      '{16'sh7FFF, 16'sh8000, 16'sh8000, 0, nil},
      '{1, 0, 0, 0, nil}, '{-1, 16'sh7FFF, 0, 0, nil}, '{1, 16'sh8000, 1, 0, nil},
      '{16'sh5555, 16'shAAAA, 16'sh1234, 0, nil}
    };

    // Map sizes: reset, extremes, degenerate and random
    phases[0] = '{-1, -1, 60, 0};
    phases[1] = '{8191, 4095, 80, 1};
    phases[2] = '{4096, 2048, 70, 0};
    phases[3] = '{1, 1, 60, 0};
    phases[4] = '{0, 100, 40, 1};
    phases[5] = '{100, 0, 40, 0};
    phases[6] = '{3, 2, 60, 0};
    phases[7] = '{-2, -2, 90, 0};
    phases[8] = '{-2, -2, 90, 1};

    for (int p = 0; p < N_PHASES; p++) begin
      if (phases[p].w == -2) begin
        write_reg(REG_MAP_WIDTH, $urandom_range(1, 8191));
        write_reg(REG_MAP_HEIGHT, $urandom_range(1, 8191));
      end else if (phases[p].w >= 0) begin
        write_reg(REG_MAP_WIDTH, phases[p].w);
        write_reg(REG_MAP_HEIGHT, phases[p].h);
      end
      rx_fast = phases[p].fast;
      if (p == 1) begin
        foreach (dir_tab[i])
          send_dir(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                   phases[p].fast ? 0 : $urandom_range(0, 17), dir_tab[i].typed,
                   dir_tab[i].res);
      end
      for (int i = 0; i < phases[p].n; i++) begin
        gap = phases[p].fast ? 0 : $urandom_range(0, 17);
        send_dir(rand_comp(), rand_comp(), rand_comp(), gap, 1'b0, nil);
      end
      // Pause until every item has come back before touching the map size
      drain();
    end

    if (mismatches == 0) begin
      $display("latlong_texel_address: match");
    end else begin
      $display("latlong_texel_address: mismatch");
    end
    $finish;
  end

endmodule
